[rtl/gyro_bias_calibrator_macros.svh]
// Assertion macros shared by the gyro bias calibrator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef GYRO_BIAS_CALIBRATOR_MACROS_SVH
`define GYRO_BIAS_CALIBRATOR_MACROS_SVH

// same-cycle implication
`define GBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/gbc_pkg.sv]
// Types and constants for the gyro bias calibrator.
// No dependencies; imported by the top level, the checker and the testbench.
`timescale 1ns / 1ps

package gbc_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic       REG_SETTLE_FRAMES = 1'b0;
   localparam logic [15:0] SETTLE_RESET     = 16'd30;

   localparam logic FUNC_FRAME   = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   typedef struct packed {
      logic               func;
      logic signed [15:0] rate_sample;
      logic               sensor_crashed;
   } req_type;

   typedef struct packed {
      logic signed [15:0] rate_corrected;
      logic               calibrating;
   } rsp_type;

endpackage

[rtl/gyro_bias_calibrator.sv]
// Gyro z-rate zero-bias calibrator, top level.
// Depends on gbc_pkg.
//
// Usage: req_* carries one transfer per IMU frame or restart command
// (valid/ready). rsp_* returns exactly one result per accepted request,
// in order, in the cycle after acceptance. csr_* is an APB-style port; the
// only register, settle_frames, sits at byte address 0 (write while idle).
// Throughput is one transfer per cycle. After the frame that completes the
// sample window, req_ready drops while the bias is divided out by a two-part
// reciprocal multiply (states div1, div2); all other frames pass at full rate.
// Reset (synchronous, active high) restores settle_frames to 30, starts a
// calibration and empties the result register.
// When the receiver stalls, the result register holds its transfer and a
// new request is taken only in a cycle where that register drains or is
// empty.
`timescale 1ns / 1ps

module gyro_bias_calibrator
   import gbc_pkg::*;
#(
   parameter int unsigned CAL_SAMPLES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int unsigned     DIVISOR  = 2 * CAL_SAMPLES;
   localparam int unsigned     SHIFT    = 34;
   localparam logic [33:0]     RECIP    = 34'(((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR);
   localparam logic [8:0]      N_TARGET = 9'(CAL_SAMPLES);

   logic [15:0]        settle_frames_ff;
   logic               cal_active_ff, cal_active_in;
   logic [15:0]        settle_left_ff, settle_left_in;
   logic [8:0]         samples_ff, samples_in;
   logic signed [23:0] sum_ff, sum_in;
   logic signed [15:0] bias_ff, bias_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               div1_ff, div1_in;
   logic               div2_ff;
   logic [41:0]        pp_lo_ff, pp_hi_ff;
   logic               neg_ff;

   logic               accept;
   logic [23:0]        mag;
   logic [24:0]        num;
   logic [58:0]        prod;
   logic [15:0]        quot;
   logic signed [16:0] diff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_SETTLE_FRAMES) ?
                       CSR_DATA_W'(settle_frames_ff) : '0;

   assign req_ready = !div1_ff && !div2_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // bias = round(sum / N), ties away from zero: floor((2|s| + N) / 2N)
   assign mag  = sum_ff[23] ? 24'(-sum_ff) : 24'(sum_ff);
   assign num  = {mag, 1'b0} + 25'(CAL_SAMPLES);
   assign prod = {pp_hi_ff, 17'b0} + 59'(pp_lo_ff);
   assign quot = prod[SHIFT +: 16];

   always_comb begin
      cal_active_in  = cal_active_ff;
      settle_left_in = settle_left_ff;
      samples_in     = samples_ff;
      sum_in         = sum_ff;
      bias_in        = bias_ff;
      div1_in        = 1'b0;
      rsp_data_in    = rsp_data_ff;
      diff = 17'({req_data.rate_sample[15], req_data.rate_sample})
           - 17'({bias_ff[15], bias_ff});
      if (div2_ff) begin
         bias_in = neg_ff ? 16'(-quot) : 16'(quot);
      end
      if (accept) begin
         if (req_data.func == FUNC_RESTART) begin
            cal_active_in  = 1'b1;
            settle_left_in = settle_frames_ff;
            samples_in     = '0;
            sum_in         = '0;
            bias_in        = '0;
            rsp_data_in    = '{rate_corrected: '0, calibrating: 1'b1};
         end else if (cal_active_ff) begin
            rsp_data_in = '{rate_corrected: '0, calibrating: 1'b1};
            if (settle_left_ff != '0) begin
               settle_left_in = settle_left_ff - 16'd1;
            end else if (!req_data.sensor_crashed) begin
               sum_in     = sum_ff + 24'(req_data.rate_sample);
               samples_in = samples_ff + 9'd1;
               if (samples_in >= N_TARGET) begin
                  cal_active_in = 1'b0;
                  div1_in       = 1'b1;
               end
            end
         end else if (req_data.sensor_crashed) begin
            rsp_data_in = '{rate_corrected: '0, calibrating: 1'b0};
         end else if (diff[16] != diff[15]) begin
            rsp_data_in.rate_corrected = diff[16] ? 16'sh8000 : 16'sh7fff;
            rsp_data_in.calibrating    = 1'b0;
         end else begin
            rsp_data_in = '{rate_corrected: diff[15:0], calibrating: 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_frames_ff <= SETTLE_RESET;
         cal_active_ff    <= 1'b1;
         settle_left_ff   <= SETTLE_RESET;
         samples_ff       <= '0;
         sum_ff           <= '0;
         bias_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
         div1_ff          <= 1'b0;
         div2_ff          <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == REG_SETTLE_FRAMES) begin
            settle_frames_ff <= csr_pwdata[15:0];
         end
         cal_active_ff  <= cal_active_in;
         settle_left_ff <= settle_left_in;
         samples_ff     <= samples_in;
         sum_ff         <= sum_in;
         bias_ff        <= bias_in;
         div1_ff        <= div1_in;
         div2_ff        <= div1_ff;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      pp_lo_ff    <= 42'(num) * 42'(RECIP[16:0]);
      pp_hi_ff    <= 42'(num) * 42'(RECIP[33:17]);
      neg_ff      <= sum_ff[23];
   end

endmodule

[rtl/gbc_checker.sv]
// Port-level checker for the gyro bias calibrator, bound to the top level.
// Depends on gbc_pkg and gyro_bias_calibrator_macros.svh.
`timescale 1ns / 1ps
`include "gyro_bias_calibrator_macros.svh"

module gbc_checker
   import gbc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `GBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data), "result transfer changed while stalled")

   `GBC_ASSERT_NEXT(a_one_result, clock, reset, req_valid && req_ready,
      rsp_valid, "accepted request produced no result")

   `GBC_ASSERT_NOW(a_cal_zero, clock, reset, rsp_valid && rsp_data.calibrating,
      rsp_data.rate_corrected == 16'sd0, "nonzero rate while calibrating")

   `GBC_ASSERT_NEXT(a_restart, clock, reset,
      req_valid && req_ready && req_data.func == FUNC_RESTART,
      rsp_data.calibrating, "restart result not flagged calibrating")

endmodule

bind gyro_bias_calibrator gbc_checker u_gbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[verif/gyro_bias_calibrator_tb.sv]
// Self-checking testbench for gyro_bias_calibrator: directed table, then random frames.
// Results are checked in order against row values or an in-bench calibration tracker.
// Depends on gbc_pkg and the gyro_bias_calibrator RTL.
`timescale 1ns / 1ps

module gyro_bias_calibrator_tb;
   import gbc_pkg::*;

   localparam int CAL_WINDOW  = 256;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 48;
   localparam int PHASE_ITEMS = 290;
   localparam logic [CSR_ADDR_W-1:0] SETTLE_ADDR = CSR_ADDR_W'(4 * REG_SETTLE_FRAMES);

   typedef enum logic {ROW_ITEM, ROW_SETTLE} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic               func;
      logic signed [15:0] sample;
      logic               crashed;
      int                 reps;
      bit                 typed;
      logic signed [15:0] exp_rate;
      logic               exp_cal;
      logic [15:0]        cfg;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // fixed expectation travels with the transfer it belongs to
   bit      exp_typed = 1'b0;
   rsp_type exp_fixed = '0;

   // calibration tracker
   logic               calib_busy = 1'b1;
   logic [15:0]        skip_setting = SETTLE_RESET;
   logic [15:0]        frames_to_skip = SETTLE_RESET;
   logic [8:0]         window_count = '0;
   logic signed [23:0] window_sum = '0;
   logic signed [15:0] zero_offset = '0;

   rsp_type rates_due[$];

   int mismatches = 0;
   int items_taken = 0;
   int results_seen = 0;
   int windows_done = 0;
   int saturated = 0;
   int quiet_cycles = 0;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;

   plan_row_type plan [28];

   gyro_bias_calibrator #(.CAL_SAMPLES(CAL_WINDOW)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   function automatic rsp_type track_calibration(input req_type r);
      rsp_type res;
      int      s;
      int      mag;
      int      diff;
      res.rate_corrected = '0;
      res.calibrating = 1'b1;
      if (r.func == FUNC_RESTART) begin
         calib_busy = 1'b1;
         frames_to_skip = skip_setting;
         window_count = '0;
         window_sum = '0;
         zero_offset = '0;
         return res;
      end
      res.calibrating = calib_busy;
      if (calib_busy) begin
         if (frames_to_skip != 0) begin
            frames_to_skip = frames_to_skip - 16'd1;
         end else if (!r.sensor_crashed) begin
            window_sum = window_sum + r.rate_sample;
            window_count = window_count + 9'd1;
            if (window_count == CAL_WINDOW) begin
               s = int'(window_sum);
               mag = (s < 0) ? -s : s;
               mag = (2 * mag + CAL_WINDOW) / (2 * CAL_WINDOW);
               zero_offset = 16'((s < 0) ? -mag : mag);
               calib_busy = 1'b0;
               windows_done++;
            end
         end
      end else if (!r.sensor_crashed) begin
         diff = int'(r.rate_sample) - int'(zero_offset);
         if (diff > 32767) begin
            diff = 32767;
            saturated++;
         end else if (diff < -32768) begin
            diff = -32768;
            saturated++;
         end
         res.rate_corrected = 16'(diff);
      end
      return res;
   endfunction

   task automatic note_mismatch(input string what);
      if (mismatches < 10) $display("mismatch: %s", what);
      mismatches++;
   endtask

   // receiver: random backpressure plus requested long hold-offs
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      rsp_type model;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            results_seen++;
            if (rates_due.size() == 0) begin
               note_mismatch($sformatf("unexpected result rate=%0d calibrating=%0b",
                                       got.rate_corrected, got.calibrating));
            end else begin
               want = rates_due.pop_front();
               if (got.rate_corrected !== want.rate_corrected ||
                   got.calibrating !== want.calibrating) begin
                  note_mismatch($sformatf(
                     "result %0d: rate exp %0d got %0d, calibrating exp %0b got %0b",
                     results_seen, want.rate_corrected, got.rate_corrected,
                     want.calibrating, got.calibrating));
               end
            end
         end
         if (req_valid && req_ready) begin
            model = track_calibration(req_data);
            rates_due.push_back(exp_typed ? exp_fixed : model);
            items_taken++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("gyro_bias_calibrator_tb NOT OK");
      $finish;
   end

   task automatic offer(input req_type item, input bit typed, input rsp_type fixed);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      exp_typed <= typed;
      exp_fixed <= fixed;
      @(posedge clock iff req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rates_due.size() != 0) @(posedge clock);
   endtask

   // write then read back settle_frames
   task automatic program_settle(input logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= SETTLE_ADDR;
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock iff csr_pready);
      skip_setting = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock iff csr_pready);
      if (csr_prdata[15:0] !== value) begin
         note_mismatch($sformatf("settle_frames read exp %0d got %0d", value, csr_prdata[15:0]));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      req_type            item;
      rsp_type            fixed;
      logic signed [15:0] center;
      plan = '{
         // after reset: default settle window of 30 frames
         '{ROW_ITEM,   FUNC_FRAME,   16'sh1234, 1'b0, 1,   1'b1, 16'sh0000, 1'b1, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh7fff, 1'b1, 2,   1'b1, 16'sh0000, 1'b1, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh8000, 1'b0, 27,  1'b1, 16'sh0000, 1'b1, 16'd0},
         // crashed frames while sampling are skipped
         '{ROW_ITEM,   FUNC_FRAME,   16'sh5555, 1'b1, 4,   1'b1, 16'sh0000, 1'b1, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh00ff, 1'b0, 10,  1'b0, 16'sh0000, 1'b0, 16'd0},
         '{ROW_ITEM,   FUNC_RESTART, 16'shffff, 1'b1, 1,   1'b1, 16'sh0000, 1'b1, 16'd0},
         // zero settle, full-scale positive bias
         '{ROW_SETTLE, FUNC_FRAME,   16'sh0000, 1'b0, 0,   1'b0, 16'sh0000, 1'b0, 16'd0},
         '{ROW_ITEM,   FUNC_RESTART, 16'sh0000, 1'b0, 1,   1'b1, 16'sh0000, 1'b1, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh7fff, 1'b1, 3,   1'b1, 16'sh0000, 1'b1, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh7fff, 1'b0, 256, 1'b1, 16'sh0000, 1'b1, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh8000, 1'b0, 1,   1'b1, 16'sh8000, 1'b0, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh7fff, 1'b0, 1,   1'b1, 16'sh0000, 1'b0, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh8000, 1'b1, 1,   1'b1, 16'sh0000, 1'b0, 16'd0},
         // full-scale negative bias
         '{ROW_ITEM,   FUNC_RESTART, 16'sh7fff, 1'b0, 1,   1'b1, 16'sh0000, 1'b1, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh8000, 1'b0, 256, 1'b1, 16'sh0000, 1'b1, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh7fff, 1'b0, 1,   1'b1, 16'sh7fff, 1'b0, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh0000, 1'b0, 1,   1'b1, 16'sh7fff, 1'b0, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh8000, 1'b0, 1,   1'b1, 16'sh0000, 1'b0, 16'd0},
         // negative half-step sum rounds away from zero
         '{ROW_SETTLE, FUNC_FRAME,   16'sh0000, 1'b0, 0,   1'b0, 16'sh0000, 1'b0, 16'd1},
         '{ROW_ITEM,   FUNC_RESTART, 16'sh1234, 1'b1, 1,   1'b1, 16'sh0000, 1'b1, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh7abc, 1'b1, 1,   1'b1, 16'sh0000, 1'b1, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'shff80, 1'b0, 1,   1'b0, 16'sh0000, 1'b0, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh0000, 1'b0, 255, 1'b0, 16'sh0000, 1'b0, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh0000, 1'b0, 2,   1'b0, 16'sh0000, 1'b0, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh7fff, 1'b0, 1,   1'b0, 16'sh0000, 1'b0, 16'd0},
         // longest settle window
         '{ROW_SETTLE, FUNC_FRAME,   16'sh0000, 1'b0, 0,   1'b0, 16'sh0000, 1'b0, 16'hffff},
         '{ROW_ITEM,   FUNC_RESTART, 16'sh0000, 1'b0, 1,   1'b1, 16'sh0000, 1'b1, 16'd0},
         '{ROW_ITEM,   FUNC_FRAME,   16'sh4000, 1'b0, 5,   1'b1, 16'sh0000, 1'b1, 16'd0}
      };

      snd_idle_pct = 27;
      rcv_idle_pct = 65;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_SETTLE) begin
            drain();
            program_settle(plan[i].cfg);
         end else begin
            for (int k = 0; k < plan[i].reps; k++) begin
               item.func = plan[i].func;
               item.rate_sample = plan[i].sample;
               item.sensor_crashed = plan[i].crashed;
               fixed.rate_corrected = plan[i].exp_rate;
               fixed.calibrating = plan[i].exp_cal;
               offer(item, plan[i].typed, fixed);
            end
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         snd_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 65 : 0;
         rcv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 27 : 0;
         drain();
         program_settle(16'($urandom_range(0, 12)));
         center = 16'($urandom);
         item.func = FUNC_RESTART;
         item.rate_sample = 16'($urandom);
         item.sensor_crashed = 1'($urandom);
         offer(item, 1'b0, '0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == 120 && ph < 2) holds_asked++;
            if ($urandom_range(0, 399) == 0) begin
               item.func = FUNC_RESTART;
               item.rate_sample = 16'($urandom);
               item.sensor_crashed = 1'($urandom);
               center = 16'($urandom);
            end else begin
               item.func = FUNC_FRAME;
               item.sensor_crashed = ($urandom_range(0, 9) == 0);
               case ($urandom_range(0, 3))
                  0: item.rate_sample = 16'($urandom);
                  1: item.rate_sample = $urandom_range(0, 1) ?
                                        16'(16'sh7fff - $urandom_range(0, 3)) :
                                        16'(16'sh8000 + $urandom_range(0, 3));
                  default: item.rate_sample = 16'(center + $urandom_range(0, 511) - 256);
               endcase
            end
            offer(item, 1'b0, '0);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (rates_due.size() != 0) begin
         note_mismatch($sformatf("%0d results never arrived", rates_due.size()));
      end
      $display("covered %0d frames and restarts, %0d results checked", items_taken, results_seen);
      $display("%0d calibration windows completed, %0d saturated outputs, %0d mismatches",
               windows_done, saturated, mismatches);
      if (mismatches == 0) begin
         $display("gyro_bias_calibrator_tb OK");
      end else begin
         $display("gyro_bias_calibrator_tb NOT OK");
      end
      $finish;
   end

endmodule

[gyro_bias_calibrator.f]
+incdir+rtl
rtl/gbc_pkg.sv
rtl/gyro_bias_calibrator.sv
rtl/gbc_checker.sv
verif/gyro_bias_calibrator_tb.sv
